[hdl/xrs_pkg.sv]
// shared types and constants for the xorshift64* random source
// used by xrs_ctrl, xrs_dpath and xorshift_random_source
package xrs_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CntW  = 6;

  localparam logic [WordW-1:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MULT_K     = 64'd2685821657736338717;

  localparam int unsigned SHIFT_A    = 12;
  localparam int unsigned SHIFT_B    = 25;
  localparam int unsigned SHIFT_C    = 27;
  localparam int unsigned FRAC_SHIFT = 11;

  localparam logic [1:0] MODE_RAW32  = 2'd0;
  localparam logic [1:0] MODE_RAW64  = 2'd1;
  localparam logic [1:0] MODE_FRAC   = 2'd2;
  localparam logic [1:0] MODE_RANGED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_MUL,
    S_MOD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic advance;
    logic mul_step;
    logic mod_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ranged;
    logic empty;
    logic cnt_last;
  } sts_t;

endpackage

[hdl/xrs_dpath.sv]
// datapath: generator state, shift-add multiplier, restoring modulo, output register
// depends on xrs_pkg
module xrs_dpath
  import xrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_wr_en,
  input  logic [WordW-1:0] seed_wr_data,
  input  logic [1:0]       in_mode,
  input  logic [HalfW-1:0] in_low,
  input  logic [HalfW-1:0] in_high,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [WordW-1:0] value
);

  logic [WordW-1:0] gen_state;
  logic [WordW-1:0] gen_next;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] mcand;
  logic [HalfW-1:0] rem;
  logic [CntW-1:0]  cnt;
  logic [1:0]       mode;
  logic [HalfW-1:0] low;
  logic [HalfW-1:0] high;
  logic [HalfW-1:0] span;
  logic [HalfW:0]   trial;
  logic [HalfW:0]   trial_diff;
  logic [HalfW-1:0] ranged_sum;
  logic [WordW-1:0] result;

  always_comb begin
    gen_next = gen_state ^ (gen_state >> SHIFT_A);
    gen_next = gen_next ^ (gen_next << SHIFT_B);
    gen_next = gen_next ^ (gen_next >> SHIFT_C);
  end

  assign span       = high - low;
  assign trial      = {rem, acc[WordW-1]};
  assign trial_diff = trial - {1'b0, span};
  assign ranged_sum = low + rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET | 64'd1;
    end else if (seed_wr_en) begin
      gen_state <= seed_wr_data | 64'd1;
    end else if (cmd.advance) begin
      gen_state <= gen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode <= in_mode;
      low  <= in_low;
      high <= in_high;
    end
    if (cmd.advance) begin
      acc   <= '0;
      mcand <= gen_next;
      rem   <= '0;
      cnt   <= '0;
    end else if (cmd.mul_step) begin
      if (MULT_K[cnt]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand << 1;
      cnt   <= cnt + 1'b1;
    end else if (cmd.mod_step) begin
      if (!trial_diff[HalfW]) begin
        rem <= trial_diff[HalfW-1:0];
      end else begin
        rem <= trial[HalfW-1:0];
      end
      acc <= acc << 1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.load_out) begin
      value <= result;
    end
  end

  always_comb begin
    case (mode)
      MODE_RAW32: result = {{HalfW{acc[HalfW-1]}}, acc[HalfW-1:0]};
      MODE_RAW64: result = acc;
      MODE_FRAC:  result = acc >> FRAC_SHIFT;
      default: begin
        if (sts.empty) begin
          result = {{HalfW{low[HalfW-1]}}, low};
        end else begin
          result = {{HalfW{ranged_sum[HalfW-1]}}, ranged_sum};
        end
      end
    endcase
  end

  assign sts.ranged   = (mode == MODE_RANGED);
  assign sts.empty    = ($signed(high) <= $signed(low));
  assign sts.cnt_last = (cnt == {CntW{1'b1}});

endmodule

[hdl/xrs_ctrl.sv]
// controller: sequences accept, advance, multiply, modulo and output load
// depends on xrs_pkg
module xrs_ctrl
  import xrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_ADV;
      end
      S_ADV: begin
        if (sts.ranged && sts.empty) state_next = S_FINISH;
        else state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.cnt_last) state_next = sts.ranged ? S_MOD : S_FINISH;
      end
      S_MOD: begin
        if (sts.cnt_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      S_ADV:    cmd.advance  = !(sts.ranged && sts.empty);
      S_MUL:    cmd.mul_step = 1'b1;
      S_MOD:    cmd.mod_step = 1'b1;
      S_FINISH: cmd.load_out = out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_no_advance_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> !(sts.ranged && sts.empty))
    else $error("state advanced on an empty range");

  a_mul_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && sts.cnt_last) |=> (state == S_MOD || state == S_FINISH))
    else $error("multiply did not finish after its last step");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FINISH)
    else $error("result shown without finishing an item");

endmodule

[hdl/xorshift_random_source.sv]
// Top level of the xorshift64* random source. Each accepted item is taken
// in, advances the state, runs the bit-serial shift-add multiply and loads
// the result. Ranged mode adds a restoring modulo, one quotient bit per
// cycle, between the multiply and the load. An empty range returns range_low and
// leaves the state as it was. The result register lets the next item be
// accepted while a result waits. A seed write reloads the state with bit 0
// forced to 1 at once, even in the middle of an item, so it belongs only
// where no item is in flight.
// depends on xrs_pkg, xrs_ctrl and xrs_dpath
module xorshift_random_source
  import xrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_wr_en,
  input  logic [WordW-1:0] seed_wr_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [WordW-1:0] s_tdata,   // range_low [31:0], range_high [63:32]
  input  logic [1:0]       s_tuser,   // mode [1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [WordW-1:0] m_tdata    // value [63:0]
);

  cmd_t cmd;
  sts_t sts;

  xrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xrs_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .in_mode      (s_tuser),
    .in_low       (s_tdata[HalfW-1:0]),
    .in_high      (s_tdata[WordW-1:HalfW]),
    .cmd          (cmd),
    .sts          (sts),
    .value        (m_tdata)
  );

endmodule

[sim/xrs_value_check.sv]
// value checker for the xorshift64* random source: tracks the seed port and
// both stream channels, predicts every returned value and compares it in order
// depends on xrs_pkg
`timescale 1ns / 1ps
module xrs_value_check
  import xrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_wr_en,
  input  logic [WordW-1:0] seed_wr_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [WordW-1:0] s_tdata,   // range_low [31:0], range_high [63:32]
  input  logic [1:0]       s_tuser,   // mode [1:0]
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [WordW-1:0] m_tdata,   // value [63:0]
  output int               mismatches,
  output int               values_owed,
  output int               values_seen,
  output int               empty_ranges
);

  logic [WordW-1:0] gen_state;
  logic [WordW-1:0] queued_values[$];

  function automatic logic [WordW-1:0] xorshift_next(input logic [WordW-1:0] x);
    x ^= x >> SHIFT_A;
    x ^= x << SHIFT_B;
    x ^= x >> SHIFT_C;
    return x;
  endfunction

  function automatic logic [WordW-1:0] sign_extend(input logic [HalfW-1:0] v);
    return {{HalfW{v[HalfW-1]}}, v};
  endfunction

  initial begin
    mismatches = 0;
    values_owed = 0;
    values_seen = 0;
    empty_ranges = 0;
  end

  always @(posedge clk) begin : watch
    logic [WordW-1:0] raw;
    logic [WordW-1:0] rem;
    logic [WordW-1:0] want;
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] span;
    logic [1:0]       mode;
    if (rst) begin
      gen_state = SEED_RESET | 64'd1;
      queued_values.delete();
      values_owed = 0;
    end else begin
      if (seed_wr_en) begin
        gen_state = seed_wr_data | 64'd1;
      end
      if (m_tvalid && m_tready) begin
        if (queued_values.size() == 0) begin
          $error("value: expected none, actual %h", m_tdata);
          mismatches++;
        end else begin
          want = queued_values.pop_front();
          if (m_tdata !== want) begin
            $error("value: expected %h, actual %h", want, m_tdata);
            mismatches++;
          end
          values_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        mode = s_tuser;
        lo = s_tdata[HalfW-1:0];
        hi = s_tdata[WordW-1:HalfW];
        if (mode == MODE_RANGED && $signed(hi) <= $signed(lo)) begin
          // empty range: state holds, low bound comes back
          want = sign_extend(lo);
          empty_ranges++;
        end else begin
          gen_state = xorshift_next(gen_state);
          raw = gen_state * MULT_K;
          case (mode)
            MODE_RAW32: want = sign_extend(raw[HalfW-1:0]);
            MODE_RAW64: want = raw;
            MODE_FRAC:  want = raw >> FRAC_SHIFT;
            default: begin
              span = hi - lo;
              rem = raw % {{HalfW{1'b0}}, span};
              want = sign_extend(lo + rem[HalfW-1:0]);
            end
          endcase
        end
        queued_values.push_back(want);
      end
      values_owed = queued_values.size();
    end
  end

endmodule

[sim/xorshift_random_source_tb.sv]
// testbench top for the xorshift64* random source: directed and random request
// items over several seeds with stalls on both sides, checked by xrs_value_check
// depends on xrs_pkg, xrs_value_check and xorshift_random_source
`timescale 1ns / 1ps
module xorshift_random_source_tb;
  import xrs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SeedPhases = 5;
  localparam int unsigned PhaseItems = 100;
  localparam logic [HalfW-1:0] IntMin = 32'h8000_0000;
  localparam logic [HalfW-1:0] IntMax = 32'h7FFF_FFFF;

  logic             clk;
  logic             rst;
  logic             seed_wr_en;
  logic [WordW-1:0] seed_wr_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [WordW-1:0] s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [WordW-1:0] m_tdata;

  int mismatches;
  int values_owed;
  int values_seen;
  int empty_ranges;
  int send_idle = 9;
  int recv_idle = 58;
  int unsigned cycle_count;
  bit hold_done = 1'b0;

  xorshift_random_source dut (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

  xrs_value_check value_check (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .values_owed  (values_owed),
    .values_seen  (values_seen),
    .empty_ranges (empty_ranges)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // output side: random stalls, plus one long hold-off to back up the input
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && values_seen >= 40) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (600) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [HalfW-1:0] lo,
                           input logic [HalfW-1:0] hi);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_bound(output logic [HalfW-1:0] v);
    case ($urandom_range(0, 4))
      0: v = IntMin;
      1: v = IntMax;
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
  endtask

  task automatic send_random_item();
    logic [1:0]       mode;
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    mode = 2'($urandom_range(0, 3));
    lo = $urandom;
    hi = $urandom;
    if (mode == MODE_RANGED) begin
      case ($urandom_range(0, 3))
        0: ;
        1: hi = lo + $urandom_range(1, 16);
        2: hi = lo + (32'd1 << $urandom_range(0, 31));
        default: begin
          pick_bound(lo);
          pick_bound(hi);
        end
      endcase
    end
    send_item(mode, lo, hi);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (values_owed != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [WordW-1:0] v);
    seed_wr_en   <= 1'b1;
    seed_wr_data <= v;
    @(negedge clk);
    seed_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [WordW-1:0] seeds [SeedPhases];
    rst          = 1'b1;
    seed_wr_en   = 1'b0;
    seed_wr_data = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = MODE_RAW32;
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = 64'h8000_0000_0000_0000;
    seeds[3] = {$urandom, $urandom} & ~64'd1;
    seeds[4] = 64'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items on the reset seed
    send_item(MODE_RAW32,  '1, '1);
    send_item(MODE_RAW64,  '0, '0);
    send_item(MODE_FRAC,   IntMin, IntMax);
    send_item(MODE_RANGED, IntMin, IntMax);
    send_item(MODE_RANGED, 32'd0, 32'd1);
    send_item(MODE_RANGED, 32'd7, 32'd7);
    send_item(MODE_RANGED, 32'd5, 32'hFFFF_FFFB);
    send_item(MODE_RANGED, IntMax, IntMin);
    send_item(MODE_RANGED, IntMin, IntMin);
    send_item(MODE_RANGED, '1, 32'd0);
    send_item(MODE_RANGED, IntMin, IntMin + 32'd1);
    send_item(MODE_RANGED, IntMax - 32'd1, IntMax);
    send_item(MODE_RANGED, IntMin, 32'd0);
    send_item(MODE_RANGED, '1, IntMax);
    send_item(MODE_RANGED, 32'hFFFF_FF9C, 32'd100);
    send_item(MODE_RANGED, 32'd0, IntMax);
    send_item(MODE_RAW32,  '0, '0);
    send_item(MODE_RAW64,  '1, '1);
    send_item(MODE_FRAC,   '0, '0);

    for (int p = 0; p < SeedPhases; p++) begin
      drain();
      write_seed(seeds[p]);
      if (p < 2) begin
        send_idle = 9;
        recv_idle = 58;
      end else if (p < 4) begin
        send_idle = 58;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (PhaseItems) send_random_item();
    end

    drain();
    repeat (150) @(posedge clk);
    $display("covered %0d values over six seeds incl. zero and all ones, %0d empty ranges,",
             values_seen, empty_ranges);
    $display("all four modes with stalls on both sides and one long output hold-off");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[xorshift_random_source.f]
hdl/xrs_pkg.sv
hdl/xrs_dpath.sv
hdl/xrs_ctrl.sv
hdl/xorshift_random_source.sv
sim/xrs_value_check.sv
sim/xorshift_random_source_tb.sv
